// ===== rtl/core/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, constants and the microcode store of the rational arithmetic
// unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int NUM_OUT_W         = 33;
  localparam int DEN_OUT_W         = 31;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_ADD = 2'd0;
  localparam cmd_t CMD_SUB = 2'd1;
  localparam cmd_t CMD_MUL = 2'd2;
  localparam cmd_t CMD_DIV = 2'd3;

  typedef enum logic [3:0] {
    U_IDLE     = 4'd0,
    U_CHECK    = 4'd1,
    U_SPLIT    = 4'd2,
    U_GCD      = 4'd3,
    U_DIV_INIT = 4'd4,
    U_DIV      = 4'd5,
    U_T1       = 4'd6,
    U_T2       = 4'd7,
    U_L        = 4'd8,
    U_DEN      = 4'd9,
    U_MUL_NUM  = 4'd10,
    U_MUL_DEN  = 4'd11,
    U_MUL_FIX  = 4'd12,
    U_OUT      = 4'd13
  } upc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_GCD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_P1F1,
    MUL_P2F2,
    MUL_F2Q2,
    MUL_NUMER,
    MUL_DENOM
  } mul_sel_t;

  typedef enum logic [1:0] {
    NUM_HOLD,
    NUM_LOAD,
    NUM_ADDSUB,
    NUM_NEGCOND
  } num_op_t;

  typedef enum logic [1:0] {
    DEN_HOLD,
    DEN_LOAD,
    DEN_ABS
  } den_op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_IN_BEAT,
    COND_ERR,
    COND_MULDIV,
    COND_GCD_RUN,
    COND_DIV_RUN,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    dp_op_t   dp_op;
    mul_sel_t mul_sel;
    num_op_t  num_op;
    den_op_t  den_op;
    cond_t    cond;
    upc_t     tgt_t;
    upc_t     tgt_f;
  } uword_t;

  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    unique case (pc)
      U_IDLE:     w = '{OP_LOAD,     MUL_NONE,  NUM_HOLD,    DEN_HOLD, COND_IN_BEAT,
                        U_CHECK, U_IDLE};
      U_CHECK:    w = '{OP_NOP,      MUL_NONE,  NUM_HOLD,    DEN_HOLD, COND_ERR,
                        U_OUT, U_SPLIT};
      U_SPLIT:    w = '{OP_NOP,      MUL_NONE,  NUM_HOLD,    DEN_HOLD, COND_MULDIV,
                        U_MUL_NUM, U_GCD};
      U_GCD:      w = '{OP_GCD,      MUL_NONE,  NUM_HOLD,    DEN_HOLD, COND_GCD_RUN,
                        U_GCD, U_DIV_INIT};
      U_DIV_INIT: w = '{OP_DIV_INIT, MUL_NONE,  NUM_HOLD,    DEN_HOLD, COND_NEVER,
                        U_DIV, U_DIV};
      U_DIV:      w = '{OP_DIV_STEP, MUL_NONE,  NUM_HOLD,    DEN_HOLD, COND_DIV_RUN,
                        U_DIV, U_T1};
      U_T1:       w = '{OP_NOP,      MUL_P1F1,  NUM_HOLD,    DEN_HOLD, COND_NEVER,
                        U_T2, U_T2};
      U_T2:       w = '{OP_NOP,      MUL_P2F2,  NUM_LOAD,    DEN_HOLD, COND_NEVER,
                        U_L, U_L};
      U_L:        w = '{OP_NOP,      MUL_F2Q2,  NUM_ADDSUB,  DEN_HOLD, COND_NEVER,
                        U_DEN, U_DEN};
      U_DEN:      w = '{OP_NOP,      MUL_NONE,  NUM_HOLD,    DEN_LOAD, COND_NEVER,
                        U_OUT, U_OUT};
      U_MUL_NUM:  w = '{OP_NOP,      MUL_NUMER, NUM_HOLD,    DEN_HOLD, COND_NEVER,
                        U_MUL_DEN, U_MUL_DEN};
      U_MUL_DEN:  w = '{OP_NOP,      MUL_DENOM, NUM_LOAD,    DEN_HOLD, COND_NEVER,
                        U_MUL_FIX, U_MUL_FIX};
      U_MUL_FIX:  w = '{OP_NOP,      MUL_NONE,  NUM_NEGCOND, DEN_ABS,  COND_NEVER,
                        U_OUT, U_OUT};
      U_OUT:      w = '{OP_OUT,      MUL_NONE,  NUM_HOLD,    DEN_HOLD, COND_OUT_BUSY,
                        U_OUT, U_IDLE};
      default:    w = '{OP_NOP,      MUL_NONE,  NUM_HOLD,    DEN_HOLD, COND_NEVER,
                        U_IDLE, U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/rau_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau channel interfaces
// Operand channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface rau_in_if #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  rau_pkg::cmd_t                   cmd;
  logic signed [OPERAND_WIDTH-1:0] a_num;
  logic        [OPERAND_WIDTH-2:0] a_den;
  logic signed [OPERAND_WIDTH-1:0] b_num;
  logic        [OPERAND_WIDTH-2:0] b_den;

  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rau_pkg::NUM_OUT_W-1:0] res_num;
  logic        [rau_pkg::DEN_OUT_W-1:0] res_den;
  logic                                status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ===== rtl/core/rational_arith_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit_top
// Fraction add, subtract, multiply and divide, run by a small microprogram
// over a binary gcd, a two-lane shift-subtract divider and one multiplier.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    cmd, a_num, a_den, b_num, b_den
//   out_ch   out  valid/ready    res_num, res_den, status
//
// add/subtract: binary gcd, two-lane divide by it, cross products, sum or
//   difference, lcm denominator; multiply/divide: products, sign fix;
// bad fraction or divide by zero goes from the check straight to output
// one beat in flight; a waiting result holds the microprogram at its last step
// rst_n is synchronous and returns the step counter to idle
// ----------------------------------------------------------------------------
module rational_arith_unit_top #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);

  import rau_pkg::*;

  localparam int W         = OPERAND_WIDTH;
  localparam int DEN_W     = W - 1;
  localparam int KW        = $clog2(W);
  localparam int PROD_W    = 2 * W;
  localparam int NUM_W     = 2 * W + 1;
  localparam int EXT_W     = (NUM_W > NUM_OUT_W) ? NUM_W : NUM_OUT_W;
  localparam int DEN_EXT_W = (PROD_W > DEN_OUT_W + 1) ? PROD_W : DEN_OUT_W + 1;

  localparam logic signed [EXT_W-1:0] NUM_HI =
    {{(EXT_W-NUM_OUT_W+1){1'b0}}, {(NUM_OUT_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] NUM_LO =
    {{(EXT_W-NUM_OUT_W+1){1'b1}}, {(NUM_OUT_W-1){1'b0}}};
  localparam logic [DEN_EXT_W-1:0] DEN_HI =
    {{(DEN_EXT_W-DEN_OUT_W){1'b0}}, {DEN_OUT_W{1'b1}}};

  upc_t                       pc_r, pc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  uword_t                     uw;
  logic                       cond_hit;
  logic                       out_busy;

  cmd_t                       cmd_r, cmd_nxt;
  logic signed [W-1:0]        a_num_r, a_num_nxt, b_num_r, b_num_nxt;
  logic [DEN_W-1:0]           a_den_r, a_den_nxt, b_den_r, b_den_nxt;
  logic                       err_r, err_nxt;
  logic [DEN_W-1:0]           u_r, u_nxt, v_r, v_nxt, g_r, g_nxt;
  logic [KW-1:0]              k_r, k_nxt, cnt_r, cnt_nxt;
  logic [DEN_W-1:0]           rem_r [2];
  logic [DEN_W-1:0]           rem_nxt [2];
  logic [DEN_W-1:0]           quo_r [2];
  logic [DEN_W-1:0]           quo_nxt [2];
  logic [DEN_W:0]             rem_sh [2];
  logic                       quo_bit [2];

  logic signed [W-1:0]        mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_res;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [NUM_W-1:0]    num_r, num_nxt, prod_ext;
  logic [PROD_W-1:0]          den_r, den_nxt;

  logic signed [EXT_W-1:0]    num_ext;
  logic [DEN_EXT_W-1:0]       den_ext;
  logic signed [NUM_OUT_W-1:0] res_num_r, res_num_nxt, num_sat;
  logic [DEN_OUT_W-1:0]       res_den_r, res_den_nxt, den_sat;
  logic                       status_r, status_nxt;

  // microcode fetch
  always_comb begin
    uw = ucode_rom(pc_r);
  end

  assign out_busy = out_valid_r && !out_ch.ready;

  // next step
  always_comb begin
    unique case (uw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_IN_BEAT:  cond_hit = in_ch.valid;
      COND_ERR:      cond_hit = err_r;
      COND_MULDIV:   cond_hit = (cmd_r == CMD_MUL) || (cmd_r == CMD_DIV);
      COND_GCD_RUN:  cond_hit = (u_r != v_r);
      COND_DIV_RUN:  cond_hit = (cnt_r != KW'(1));
      COND_OUT_BUSY: cond_hit = out_busy;
      default:       cond_hit = 1'b0;
    endcase
    pc_nxt = cond_hit ? uw.tgt_t : uw.tgt_f;
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.mul_sel)
      MUL_P1F1: begin
        mul_a = a_num_r;
        mul_b = $signed({1'b0, quo_r[0]});
      end
      MUL_P2F2: begin
        mul_a = b_num_r;
        mul_b = $signed({1'b0, quo_r[1]});
      end
      MUL_F2Q2: begin
        mul_a = $signed({1'b0, quo_r[1]});
        mul_b = $signed({1'b0, b_den_r});
      end
      MUL_NUMER: begin
        mul_a = a_num_r;
        mul_b = (cmd_r == CMD_DIV) ? $signed({1'b0, b_den_r}) : b_num_r;
      end
      MUL_DENOM: begin
        mul_a = $signed({1'b0, a_den_r});
        mul_b = (cmd_r == CMD_DIV) ? b_num_r : $signed({1'b0, b_den_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res  = mul_a * mul_b;
  assign prod_ext = NUM_W'(prod_r);

  // divider lanes
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i]  = {rem_r[i], quo_r[i][DEN_W-1]};
      quo_bit[i] = (rem_sh[i] >= {1'b0, g_r});
    end
  end

  // result saturation
  always_comb begin
    num_ext = EXT_W'(num_r);
    den_ext = DEN_EXT_W'(den_r);
    if (num_ext > NUM_HI) begin
      num_sat = NUM_HI[NUM_OUT_W-1:0];
    end else if (num_ext < NUM_LO) begin
      num_sat = NUM_LO[NUM_OUT_W-1:0];
    end else begin
      num_sat = num_ext[NUM_OUT_W-1:0];
    end
    den_sat = (den_ext > DEN_HI) ? DEN_HI[DEN_OUT_W-1:0] : den_ext[DEN_OUT_W-1:0];
  end

  // datapath control
  always_comb begin
    cmd_nxt       = cmd_r;
    a_num_nxt     = a_num_r;
    a_den_nxt     = a_den_r;
    b_num_nxt     = b_num_r;
    b_den_nxt     = b_den_r;
    err_nxt       = err_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    status_nxt    = status_r;
    out_valid_nxt = out_busy;
    prod_nxt      = (uw.mul_sel != MUL_NONE) ? mul_res : prod_r;

    unique case (uw.dp_op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          a_num_nxt = in_ch.a_num;
          a_den_nxt = in_ch.a_den;
          b_num_nxt = in_ch.b_num;
          b_den_nxt = in_ch.b_den;
          err_nxt   = (in_ch.a_den == '0) || (in_ch.b_den == '0) ||
                      ((in_ch.cmd == CMD_DIV) && (in_ch.b_num == '0));
          u_nxt     = in_ch.a_den;
          v_nxt     = in_ch.b_den;
          k_nxt     = '0;
        end
      end
      OP_GCD: begin
        if (u_r != v_r) begin
          if (!u_r[0] && !v_r[0]) begin
            u_nxt = u_r >> 1;
            v_nxt = v_r >> 1;
            k_nxt = k_r + KW'(1);
          end else if (!u_r[0]) begin
            u_nxt = u_r >> 1;
          end else if (!v_r[0]) begin
            v_nxt = v_r >> 1;
          end else if (u_r > v_r) begin
            u_nxt = (u_r - v_r) >> 1;
          end else begin
            v_nxt = (v_r - u_r) >> 1;
          end
        end
      end
      OP_DIV_INIT: begin
        g_nxt      = u_r << k_r;
        quo_nxt[0] = b_den_r;
        quo_nxt[1] = a_den_r;
        rem_nxt[0] = '0;
        rem_nxt[1] = '0;
        cnt_nxt    = KW'(DEN_W);
      end
      OP_DIV_STEP: begin
        for (int i = 0; i < 2; i++) begin
          rem_nxt[i] = quo_bit[i] ? DEN_W'(rem_sh[i] - {1'b0, g_r})
                                  : rem_sh[i][DEN_W-1:0];
          quo_nxt[i] = {quo_r[i][DEN_W-2:0], quo_bit[i]};
        end
        cnt_nxt = cnt_r - KW'(1);
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            res_num_nxt = '0;
            res_den_nxt = '0;
            status_nxt  = 1'b1;
          end else begin
            res_num_nxt = num_sat;
            res_den_nxt = den_sat;
            status_nxt  = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    case (uw.num_op)
      NUM_LOAD:    num_nxt = prod_ext;
      NUM_ADDSUB:  num_nxt = (cmd_r == CMD_SUB) ? num_r - prod_ext : num_r + prod_ext;
      NUM_NEGCOND: num_nxt = prod_r[PROD_W-1] ? -num_r : num_r;
      default:     num_nxt = num_r;
    endcase

    case (uw.den_op)
      DEN_LOAD: den_nxt = prod_r;
      DEN_ABS:  den_nxt = prod_r[PROD_W-1] ? -prod_r : prod_r;
      default:  den_nxt = den_r;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= U_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    a_num_r   <= a_num_nxt;
    a_den_r   <= a_den_nxt;
    b_num_r   <= b_num_nxt;
    b_den_r   <= b_den_nxt;
    err_r     <= err_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    k_r       <= k_nxt;
    g_r       <= g_nxt;
    cnt_r     <= cnt_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    prod_r    <= prod_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    status_r  <= status_nxt;
  end

  assign in_ch.ready    = (pc_r == U_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.res_num = res_num_r;
  assign out_ch.res_den = res_den_r;
  assign out_ch.status  = status_r;

endmodule

// ===== rtl/core/rau_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks on the rational arithmetic unit, bound to its top level.
// ----------------------------------------------------------------------------
module rau_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [rau_pkg::NUM_OUT_W-1:0] res_num,
  input logic        [rau_pkg::DEN_OUT_W-1:0] res_den,
  input logic                                status
);

  import rau_pkg::*;

  // one beat in flight
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("operand beat taken while another is in flight");

  // error result carries a zero fraction
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status) |-> (res_num == '0) && (res_den == '0))
    else $error("error result with non-zero fraction");

  // good result never has a zero denominator
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !status) |-> (res_den != '0))
    else $error("good result with zero denominator");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      out_valid && $stable(res_num) && $stable(res_den) && $stable(status))
    else $error("stalled result changed");

endmodule

bind rational_arith_unit_top rau_checker u_rau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .res_num   (out_ch.res_num),
  .res_den   (out_ch.res_den),
  .status    (out_ch.status)
);
